### design/vdi_pkg.sv
// Shared types, constants and helpers for the vertex deduplication indexer.
`timescale 1ns / 1ps
package vdi_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int WORD_W      = 32;
	localparam int VERT_W      = 8 * WORD_W;
	localparam int INDEX_W     = 12;
	localparam int COUNT_W     = 13;

	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

	typedef struct packed {
		logic              action;
		logic [WORD_W-1:0] pos_x;
		logic [WORD_W-1:0] pos_y;
		logic [WORD_W-1:0] pos_z;
		logic [WORD_W-1:0] tex_u;
		logic [WORD_W-1:0] tex_v;
		logic [WORD_W-1:0] norm_x;
		logic [WORD_W-1:0] norm_y;
		logic [WORD_W-1:0] norm_z;
	} vdi_in_t;

	typedef struct packed {
		logic [INDEX_W-1:0] vertex_index;
		logic               is_new;
		logic               table_full;
		logic [COUNT_W-1:0] unique_count;
	} vdi_out_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [VERT_W-1:0] wr_data;
	} vdi_ram_req_t;

	function automatic logic [VERT_W-1:0] pack_vertex(input vdi_in_t item);
		return {item.pos_x, item.pos_y, item.pos_z, item.tex_u, item.tex_v,
			item.norm_x, item.norm_y, item.norm_z};
	endfunction

endpackage

### design/vdi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module vdi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### design/vdi_seq.sv
// Search sequencer: walks the vertex table one entry a cycle through a shared comparator.
`timescale 1ns / 1ps
module vdi_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vtx_valid,
	input  vdi_pkg::vdi_in_t     vtx,
	output logic                 vtx_ready,
	input  logic                 out_free,
	output logic                 result_load,
	output vdi_pkg::vdi_out_t    result,
	output vdi_pkg::vdi_ram_req_t ram_req,
	input  logic [vdi_pkg::VERT_W-1:0] ram_rdata
);
	import vdi_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_FINISH} state_t;

	state_t            state_q;
	logic [VERT_W-1:0] vert_q;
	logic              clr_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  issue_q;
	logic              cmp_v_q;
	logic [ADDR_W-1:0] cmp_addr_q;
	logic              found_q;
	logic [ADDR_W-1:0] hit_q;

	logic issuing;
	logic match;
	logic last_cmp;
	logic has_room;
	logic do_write;

	assign vtx_ready = (state_q == S_IDLE);
	assign issuing   = (state_q == S_SEARCH) && (issue_q < count_q);
	assign match     = cmp_v_q && (ram_rdata == vert_q);
	assign last_cmp  = cmp_v_q && ((CNT_W'(cmp_addr_q) + CNT_W'(1)) == count_q);
	assign has_room  = (count_q < CNT_W'(TABLE_DEPTH));

	assign result_load = (state_q == S_FINISH) && out_free;
	assign do_write    = result_load && !clr_q && !found_q && has_room;

	always_comb begin
		ram_req.rd_en   = issuing;
		ram_req.rd_addr = issue_q[ADDR_W-1:0];
		ram_req.wr_en   = do_write;
		ram_req.wr_addr = count_q[ADDR_W-1:0];
		ram_req.wr_data = vert_q;
	end

	always_comb begin
		result = '0;
		if (clr_q) begin
			result = '0;
		end else if (found_q) begin
			result.vertex_index = INDEX_W'(hit_q);
			result.unique_count = COUNT_W'(count_q);
		end else if (has_room) begin
			result.vertex_index = INDEX_W'(count_q);
			result.is_new       = 1'b1;
			result.unique_count = COUNT_W'(count_q + CNT_W'(1));
		end else begin
			result.table_full   = 1'b1;
			result.unique_count = COUNT_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			clr_q      <= 1'b0;
			count_q    <= '0;
			issue_q    <= '0;
			cmp_v_q    <= 1'b0;
			cmp_addr_q <= '0;
			found_q    <= 1'b0;
			hit_q      <= '0;
			vert_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (vtx_valid) begin
						vert_q  <= pack_vertex(vtx);
						clr_q   <= (vtx.action == ACT_CLEAR);
						issue_q <= '0;
						cmp_v_q <= 1'b0;
						found_q <= 1'b0;
						// A clear or an empty table needs no search at all.
						if (vtx.action == ACT_CLEAR || count_q == '0) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					cmp_v_q    <= issuing;
					cmp_addr_q <= issue_q[ADDR_W-1:0];
					if (issuing) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (match) begin
						found_q <= 1'b1;
						hit_q   <= cmp_addr_q;
						state_q <= S_FINISH;
					end else if (last_cmp) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (result_load) begin
						if (clr_q) begin
							count_q <= '0;
						end else if (do_write) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_write_appends: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.wr_en |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("table write did not advance the entry count");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result_load && found_q && !clr_q) |-> (CNT_W'(hit_q) < count_q))
		else $error("match reported beyond stored entries");

	a_compare_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH && cmp_v_q) |-> (CNT_W'(cmp_addr_q) < count_q))
		else $error("compared an entry that was never stored");

endmodule

### design/vertex_dedup_indexer.sv
// Top level of the vertex deduplication indexer: sequencer, vertex table RAM and result register.
//
//  channel | direction | handshake               | payload
//  vtx     | in        | vtx_valid / vtx_ready   | vtx (vdi_in_t): action and eight vertex words
//  res     | out       | res_valid / res_ready   | res (vdi_out_t): index, flags and count
//
// A lookup against N stored entries reads one entry a cycle from the table RAM and ends
// early on a hit; the result is registered once the sequencer reaches its final step.
// A clear, or a lookup into an empty table, skips the search and goes straight to that step.
// Reset empties the table through the entry count; the RAM itself needs no clearing pass.
// vtx_ready is low while an item is being worked on; a waiting result holds the sequencer
// in its final step until res_ready takes it.
`timescale 1ns / 1ps
module vertex_dedup_indexer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vtx_valid,
	output logic              vtx_ready,
	input  vdi_pkg::vdi_in_t  vtx,
	output logic              res_valid,
	input  logic              res_ready,
	output vdi_pkg::vdi_out_t res
);
	import vdi_pkg::*;

	vdi_ram_req_t      ram_req;
	logic [VERT_W-1:0] ram_rdata;
	vdi_out_t          result;
	logic              result_load;
	logic              out_free;
	logic              res_valid_q;
	vdi_out_t          res_q;

	assign out_free  = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	vdi_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.vtx_valid   (vtx_valid),
		.vtx         (vtx),
		.vtx_ready   (vtx_ready),
		.out_free    (out_free),
		.result_load (result_load),
		.result      (result),
		.ram_req     (ram_req),
		.ram_rdata   (ram_rdata)
	);

	vdi_ram #(
		.WIDTH (VERT_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_req.wr_en),
		.wr_addr (ram_req.wr_addr),
		.wr_data (ram_req.wr_data),
		.rd_en   (ram_req.rd_en),
		.rd_addr (ram_req.rd_addr),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (result_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			res_q <= result;
		end
	end

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the vertex deduplication indexer.
`timescale 1ns / 1ps
module testbench;
	import vdi_pkg::*;

	localparam int  CYCLE_LIMIT  = 1_000_000;
	localparam int  RANDOM_ITEMS = 100;
	localparam int  POOL_MAX     = 16;
	localparam int  STEADY_POOL  = 4;
	localparam int  STEADY_ITEMS = 16;
	localparam int  SETTLE       = 20;

	logic     clk;
	logic     arst_n;
	logic     vtx_valid;
	logic     vtx_ready;
	vdi_in_t  vtx;
	logic     res_valid;
	logic     res_ready;
	vdi_out_t res;

	// Our own image of the vertex table and its fill level.
	logic [VERT_W-1:0] stored_vertices [TABLE_DEPTH];
	int unsigned       stored_count;

	vdi_out_t pending_answers [$];
	int       fail_count;
	bit       bursts_on;
	int       ready_hold;

	vertex_dedup_indexer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_ready (vtx_ready),
		.vtx       (vtx),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Works out the answer for one accepted item and updates the table image.
	function automatic vdi_out_t dedup_lookup(input vdi_in_t item);
		vdi_out_t          answer;
		logic [VERT_W-1:0] key;
		int unsigned       slot;
		answer = '0;
		if (item.action == ACT_CLEAR) begin
			stored_count = 0;
			return answer;
		end
		key  = item[VERT_W-1:0];
		slot = 0;
		while (slot < stored_count && stored_vertices[slot] != key)
			slot++;
		if (slot < stored_count) begin
			answer.vertex_index = slot[INDEX_W-1:0];
		end else if (stored_count < TABLE_DEPTH) begin
			stored_vertices[slot] = key;
			answer.vertex_index   = slot[INDEX_W-1:0];
			answer.is_new         = 1'b1;
			stored_count++;
		end else begin
			answer.table_full = 1'b1;
		end
		answer.unique_count = stored_count[COUNT_W-1:0];
		return answer;
	endfunction

	function automatic logic [VERT_W-1:0] random_words();
		logic [VERT_W-1:0] w;
		int                i;
		for (i = 0; i < 8; i++)
			w[i*WORD_W +: WORD_W] = $urandom();
		return w;
	endfunction

	function automatic vdi_in_t lookup_item(input logic [VERT_W-1:0] words);
		return vdi_in_t'({ACT_LOOKUP, words});
	endfunction

	// A clear carries junk in the vertex words, which the block must ignore.
	function automatic vdi_in_t clear_item();
		return vdi_in_t'({ACT_CLEAR, random_words()});
	endfunction

	// Entered and left at a falling edge. Valid is left high after the transfer so that
	// back-to-back items need no gap; the next call replaces the item, and the end of the run lowers it.
	task automatic offer_vertex(input vdi_in_t item);
		vdi_out_t answer;
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			vtx_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		vtx_valid <= 1'b1;
		vtx       <= item;
		do @(posedge clk); while (!vtx_ready);
		answer          = dedup_lookup(item);
		pending_answers = {pending_answers, answer};
		@(negedge clk);
	endtask

	task automatic test_first_entries();
		offer_vertex(lookup_item('0));
		offer_vertex(lookup_item('1));
		offer_vertex(lookup_item('0));
		offer_vertex(lookup_item('1));
	endtask

	// Signed zeros and NaNs are distinct vertices unless the patterns agree exactly.
	task automatic test_float_patterns();
		offer_vertex(lookup_item({32'h8000_0000, {(VERT_W-WORD_W){1'b0}}}));
		offer_vertex(lookup_item({{(VERT_W-WORD_W){1'b0}}, 32'h8000_0000}));
		offer_vertex(lookup_item({8{32'h7FC0_0000}}));
		offer_vertex(lookup_item({8{32'h7FC0_0001}}));
		offer_vertex(lookup_item({8{32'h7FC0_0000}}));
		offer_vertex(lookup_item({{(VERT_W-1){1'b1}}, 1'b0}));
	endtask

	task automatic test_clear();
		offer_vertex(clear_item());
		offer_vertex(clear_item());
		offer_vertex(lookup_item('1));
		offer_vertex(lookup_item('0));
	endtask

	// Short meshes drawn from a small pool of vertices so that most lookups hit, mixed
	// with fresh vertices, single-bit near misses and the odd stray clear.
	task automatic test_random_meshes();
		logic [VERT_W-1:0] pool [POOL_MAX];
		logic [VERT_W-1:0] words;
		int                sent;
		int                pool_size;
		int                pick;
		int                i;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			bursts_on = ($urandom_range(0, 3) != 0);
			pool_size = $urandom_range(1, POOL_MAX);
			for (i = 0; i < pool_size; i++)
				pool[i] = random_words();
			if ($urandom_range(0, 1) == 0) begin
				offer_vertex(clear_item());
				sent++;
			end
			repeat ($urandom_range(4, 30)) begin
				pick = $urandom_range(0, pool_size - 1);
				case ($urandom_range(0, 19))
					0: begin
						offer_vertex(clear_item());
					end
					1, 2: begin
						offer_vertex(lookup_item(random_words()));
					end
					3, 4: begin
						words = pool[pick];
						words[$urandom_range(0, VERT_W - 1)] ^= 1'b1;
						offer_vertex(lookup_item(words));
					end
					default: begin
						offer_vertex(lookup_item(pool[pick]));
					end
				endcase
				sent++;
			end
		end
	endtask

	// A short mesh sent with no idling on either side, hits and new entries back to back.
	task automatic test_steady_stream();
		logic [VERT_W-1:0] pool [STEADY_POOL];
		int                i;
		bursts_on = 1'b0;
		for (i = 0; i < STEADY_POOL; i++)
			pool[i] = random_words();
		offer_vertex(clear_item());
		for (i = 0; i < STEADY_ITEMS; i++)
			offer_vertex(lookup_item(pool[$urandom_range(0, STEADY_POOL - 1)]));
	endtask

	always @(posedge clk) begin
		vdi_out_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_answers.size() == 0) begin
				$display("%0t: result with nothing outstanding: index %0d new %b full %b count %0d",
					$time, res.vertex_index, res.is_new, res.table_full, res.unique_count);
				fail_count++;
			end else begin
				want = pending_answers.pop_front();
				if (res.vertex_index !== want.vertex_index) begin
					$display("%0t: vertex_index expected %0d, got %0d",
						$time, want.vertex_index, res.vertex_index);
					fail_count++;
				end
				if (res.is_new !== want.is_new) begin
					$display("%0t: is_new expected %b, got %b", $time, want.is_new, res.is_new);
					fail_count++;
				end
				if (res.table_full !== want.table_full) begin
					$display("%0t: table_full expected %b, got %b",
						$time, want.table_full, res.table_full);
					fail_count++;
				end
				if (res.unique_count !== want.unique_count) begin
					$display("%0t: unique_count expected %0d, got %0d",
						$time, want.unique_count, res.unique_count);
					fail_count++;
				end
			end
		end
	end

	// The receiving side stalls in bursts while bursts are enabled.
	initial begin
		res_ready  = 1'b0;
		ready_hold = 0;
		forever begin
			@(negedge clk);
			if (ready_hold > 0) begin
				ready_hold--;
				res_ready <= 1'b0;
			end else if (bursts_on && $urandom_range(0, 15) == 0) begin
				ready_hold = $urandom_range(1, 14) - 1;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		vtx_valid    = 1'b0;
		vtx          = '0;
		bursts_on    = 1'b1;
		fail_count   = 0;
		stored_count = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_first_entries();
		test_float_patterns();
		test_clear();
		test_random_meshes();
		test_steady_stream();

		vtx_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
